>>> hw/rtl/cgp_pkg.sv
package cgp_pkg;

	typedef enum logic [2:0] {
		OP_ENTER     = 3'd0,
		OP_EXIT      = 3'd1,
		OP_READ_FUNC = 3'd2,
		OP_READ_EDGE = 3'd3,
		OP_CLEAR     = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_INACTIVE   = 3'd1,
		ST_STACK_FULL = 3'd2,
		ST_STACK_EMPTY = 3'd3,
		ST_FUNC_FULL  = 3'd4,
		ST_EDGE_FULL  = 3'd5,
		ST_RANGE      = 3'd6
	} status_t;

	localparam int ADDR_SHIFT = 4;
	localparam int KEY_W = 64 - ADDR_SHIFT;

endpackage

>>> hw/rtl/call_graph_cycle_profiler_core.sv
// Enter with a caller and exit read the stack frame, hash the key and probe slots in turn until an
// empty slot or a match; over a slot count that is not a power of two the hash is reduced serially,
// four key bits per step. An exit whose frame holds an edge then adds its cycles to that edge, reads
// fetch one entry, and other ops finish while idle. The one-cycle done strobe rises as busy falls, as
// a clear starts, or alone for an op finished while idle; one item is in work at a time and the
// receiver cannot stall. After reset, and after a clear op, a sweep empties both slot tables.
module call_graph_cycle_profiler_core #(
	parameter int FUNC_ENTRIES = 256,
	parameter int FUNC_SLOTS   = 512,
	parameter int EDGE_ENTRIES = 1024,
	parameter int EDGE_SLOTS   = 2048,
	parameter int STACK_DEPTH  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [63:0] func_addr,
	input  logic [63:0] timestamp,
	input  logic [9:0]  entry_index,
	output logic        done,
	output logic [2:0]  status,
	output logic [63:0] addr_first,
	output logic [63:0] addr_second,
	output logic [63:0] call_total,
	output logic [63:0] cycle_total,
	output logic [10:0] entries_used,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	localparam int FI  = $clog2(FUNC_ENTRIES);
	localparam int EI  = $clog2(EDGE_ENTRIES);
	localparam int FSW = $clog2(FUNC_SLOTS);
	localparam int ESW = $clog2(EDGE_SLOTS);
	localparam int HSW = (FSW > ESW) ? FSW : ESW;
	localparam int HTW = HSW + 4;
	localparam int MAXS = (FUNC_SLOTS > EDGE_SLOTS) ? FUNC_SLOTS : EDGE_SLOTS;
	localparam int CW  = $clog2(MAXS + 1);
	localparam int FUW = $clog2(FUNC_ENTRIES + 1);
	localparam int EUW = $clog2(EDGE_ENTRIES + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int LW  = $clog2(STACK_DEPTH + 1);
	localparam int SDW = 129 + EI;
	localparam int KW  = cgp_pkg::KEY_W;
	localparam bit FPOW2 = (FUNC_SLOTS & (FUNC_SLOTS - 1)) == 0;
	localparam bit EPOW2 = (EDGE_SLOTS & (EDGE_SLOTS - 1)) == 0;
	localparam logic [HSW:0] FMOD = (HSW + 1)'(FUNC_SLOTS);
	localparam logic [HSW:0] EMOD = (HSW + 1)'(EDGE_SLOTS);
	localparam logic [HSW-1:0] FMASK = HSW'(FUNC_SLOTS - 1);
	localparam logic [HSW-1:0] EMASK = HSW'(EDGE_SLOTS - 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CALLER, S_FRAME, S_HASH, S_PROBE, S_SLOT, S_ENT,
		S_XER, S_XADD, S_RFUNC, S_REDGE
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    clr_q;
	logic [CW-1:0]    n_q;
	logic [LW-1:0]    level_q;
	logic [FUW-1:0]   fused_q;
	logic [EUW-1:0]   eused_q;
	logic             en_q;
	logic             edge_op_q;
	logic [63:0]      addr_q;
	logic [63:0]      ts_q;
	logic [9:0]       ix_q;
	logic [63:0]      caller_q;
	logic [63:0]      fr_addr_q;
	logic [EI-1:0]    fr_e_q;
	logic             fr_ev_q;
	logic [63:0]      delta_q;
	logic [KW-1:0]    hv_q;
	logic [HSW-1:0]   hr_q;
	logic [5:0]       hcnt_q;
	logic [HSW-1:0]   slot_q;
	logic             done_q;
	logic [2:0]       status_q;
	logic [63:0]      a1_q, a2_q, calls_q, cycles_q;
	logic [10:0]      used_q;

	logic             fent_we, fslot_we, eent_we, eslot_we, stk_we;
	logic [FI-1:0]    fent_waddr, fent_raddr;
	logic [191:0]     fent_wdata, fent_rd;
	logic [FSW-1:0]   fslot_waddr;
	logic [FI:0]      fslot_wdata, fslot_rd;
	logic [EI-1:0]    eent_waddr, eent_raddr;
	logic [255:0]     eent_wdata, eent_rd;
	logic [ESW-1:0]   eslot_waddr;
	logic [EI:0]      eslot_wdata, eslot_rd;
	logic [SAW-1:0]   stk_waddr;
	logic [SDW-1:0]   stk_wdata, stk_rd;

	logic [31:0]      ixw, fu32, eu32;
	logic [LW-1:0]    lvl_m1;
	logic [HSW:0]     modv, s1;
	logic [HTW-1:0]   hmod, ht0, ht1, ht2, ht3, ht4;
	logic [HSW-1:0]   slot_nx;
	logic             slot_v, ent_match, probe_last;
	logic [CW-1:0]    m_last;

	assign ixw    = {22'd0, entry_index};
	assign fu32   = 32'(fused_q);
	assign eu32   = 32'(eused_q);
	assign lvl_m1 = level_q - LW'(1);
	assign modv   = edge_op_q ? EMOD : FMOD;
	assign hmod   = {3'd0, modv};
	assign ht0    = {hr_q, hv_q[KW-1:KW-4]};
	assign ht1    = (ht0 >= (hmod << 3)) ? (ht0 - (hmod << 3)) : ht0;
	assign ht2    = (ht1 >= (hmod << 2)) ? (ht1 - (hmod << 2)) : ht1;
	assign ht3    = (ht2 >= (hmod << 1)) ? (ht2 - (hmod << 1)) : ht2;
	assign ht4    = (ht3 >= hmod) ? (ht3 - hmod) : ht3;
	assign s1     = {1'b0, slot_q} + (HSW + 1)'(1);
	assign slot_nx = (s1 == modv) ? '0 : s1[HSW-1:0];
	assign slot_v = edge_op_q ? eslot_rd[EI] : fslot_rd[FI];
	assign ent_match = edge_op_q
		? (eent_rd[255:192] == caller_q && eent_rd[191:128] == addr_q)
		: (fent_rd[191:128] == fr_addr_q);
	assign m_last = edge_op_q ? CW'(EDGE_SLOTS - 1) : CW'(FUNC_SLOTS - 1);
	assign probe_last = n_q == m_last;

	assign busy         = state_q != S_IDLE;
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign status       = status_q;
	assign addr_first   = a1_q;
	assign addr_second  = a2_q;
	assign call_total   = calls_q;
	assign cycle_total  = cycles_q;
	assign entries_used = used_q;

	always_comb begin
		fent_we     = 1'b0;
		fslot_we    = 1'b0;
		eent_we     = 1'b0;
		eslot_we    = 1'b0;
		stk_we      = 1'b0;
		fent_waddr  = fused_q[FI-1:0];
		fent_wdata  = {fr_addr_q, 64'd1, delta_q};
		fslot_waddr = slot_q[FSW-1:0];
		fslot_wdata = {1'b1, fused_q[FI-1:0]};
		eent_waddr  = eused_q[EI-1:0];
		eent_wdata  = {caller_q, addr_q, 64'd1, 64'd0};
		eslot_waddr = slot_q[ESW-1:0];
		eslot_wdata = {1'b1, eused_q[EI-1:0]};
		stk_waddr   = level_q[SAW-1:0];
		stk_wdata   = {addr_q, ts_q, {EI{1'b0}}, 1'b0};
		fent_raddr  = (state_q == S_SLOT) ? fslot_rd[FI-1:0] : ixw[FI-1:0];
		eent_raddr  = ixw[EI-1:0];
		if (state_q == S_SLOT) begin
			eent_raddr = eslot_rd[EI-1:0];
		end else if (state_q == S_XER) begin
			eent_raddr = fr_e_q;
		end
		case (state_q)
			S_CLR: begin
				fslot_we    = 32'(clr_q) < 32'(FUNC_SLOTS);
				eslot_we    = 32'(clr_q) < 32'(EDGE_SLOTS);
				fslot_waddr = clr_q[FSW-1:0];
				eslot_waddr = clr_q[ESW-1:0];
				fslot_wdata = '0;
				eslot_wdata = '0;
			end
			S_IDLE: begin
				if (start && op == cgp_pkg::OP_ENTER && en_q &&
				    32'(level_q) == 0) begin
					stk_we    = 1'b1;
					stk_wdata = {func_addr, timestamp, {EI{1'b0}}, 1'b0};
				end
			end
			S_SLOT: begin
				if (!slot_v) begin
					if (edge_op_q) begin
						stk_we = 1'b1;
						if (32'(eused_q) != 32'(EDGE_ENTRIES)) begin
							eent_we   = 1'b1;
							eslot_we  = 1'b1;
							stk_wdata = {addr_q, ts_q, eused_q[EI-1:0], 1'b1};
						end
					end else if (32'(fused_q) != 32'(FUNC_ENTRIES)) begin
						fent_we  = 1'b1;
						fslot_we = 1'b1;
					end
				end
			end
			S_ENT: begin
				if (edge_op_q) begin
					eent_waddr = eslot_rd[EI-1:0];
					eent_wdata = {eent_rd[255:128], eent_rd[127:64] + 64'd1, eent_rd[63:0]};
					stk_wdata  = {addr_q, ts_q, eslot_rd[EI-1:0], 1'b1};
					if (ent_match) begin
						eent_we = 1'b1;
						stk_we  = 1'b1;
					end else if (probe_last) begin
						stk_we    = 1'b1;
						stk_wdata = {addr_q, ts_q, {EI{1'b0}}, 1'b0};
					end
				end else begin
					fent_waddr = fslot_rd[FI-1:0];
					fent_wdata = {fent_rd[191:128], fent_rd[127:64] + 64'd1,
						fent_rd[63:0] + delta_q};
					fent_we    = ent_match;
				end
			end
			S_XADD: begin
				eent_we    = 1'b1;
				eent_waddr = fr_e_q;
				eent_wdata = {eent_rd[255:64], eent_rd[63:0] + delta_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			n_q       <= '0;
			level_q   <= '0;
			fused_q   <= '0;
			eused_q   <= '0;
			en_q      <= 1'b0;
			edge_op_q <= 1'b0;
			addr_q    <= '0;
			ts_q      <= '0;
			ix_q      <= '0;
			caller_q  <= '0;
			fr_addr_q <= '0;
			fr_e_q    <= '0;
			fr_ev_q   <= 1'b0;
			delta_q   <= '0;
			hv_q      <= '0;
			hr_q      <= '0;
			hcnt_q    <= '0;
			slot_q    <= '0;
			done_q    <= 1'b0;
			status_q  <= '0;
			a1_q      <= '0;
			a2_q      <= '0;
			calls_q   <= '0;
			cycles_q  <= '0;
			used_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				en_q <= cfg_data;
			end
			case (state_q)
				S_CLR: begin
					if (32'(clr_q) == MAXS - 1) begin
						state_q <= S_IDLE;
					end
					clr_q <= clr_q + CW'(1);
				end
				S_IDLE: begin
					if (start) begin
						addr_q   <= func_addr;
						ts_q     <= timestamp;
						ix_q     <= entry_index;
						done_q   <= 1'b1;
						status_q <= cgp_pkg::ST_DONE;
						a1_q     <= '0;
						a2_q     <= '0;
						calls_q  <= '0;
						cycles_q <= '0;
						used_q   <= '0;
						n_q      <= '0;
						case (op)
							cgp_pkg::OP_ENTER: begin
								edge_op_q <= 1'b1;
								if (!en_q) begin
									status_q <= cgp_pkg::ST_INACTIVE;
								end else if (32'(level_q) == STACK_DEPTH) begin
									status_q <= cgp_pkg::ST_STACK_FULL;
								end else if (32'(level_q) == 0) begin
									level_q <= level_q + LW'(1);
								end else begin
									done_q  <= 1'b0;
									state_q <= S_CALLER;
								end
							end
							cgp_pkg::OP_EXIT: begin
								edge_op_q <= 1'b0;
								if (32'(level_q) == 0) begin
									status_q <= cgp_pkg::ST_STACK_EMPTY;
								end else begin
									done_q  <= 1'b0;
									level_q <= lvl_m1;
									state_q <= S_FRAME;
								end
							end
							cgp_pkg::OP_READ_FUNC: begin
								done_q  <= 1'b0;
								state_q <= S_RFUNC;
							end
							cgp_pkg::OP_READ_EDGE: begin
								done_q  <= 1'b0;
								state_q <= S_REDGE;
							end
							cgp_pkg::OP_CLEAR: begin
								fused_q <= '0;
								eused_q <= '0;
								clr_q   <= '0;
								state_q <= S_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				S_CALLER: begin
					caller_q <= stk_rd[SDW-1:SDW-64];
					hv_q     <= stk_rd[SDW-1:SDW-KW] ^ addr_q[63:64-KW];
					hr_q     <= '0;
					hcnt_q   <= '0;
					state_q  <= S_HASH;
				end
				S_FRAME: begin
					fr_addr_q <= stk_rd[SDW-1:SDW-64];
					delta_q   <= ts_q - stk_rd[SDW-65:SDW-128];
					fr_e_q    <= stk_rd[EI:1];
					fr_ev_q   <= stk_rd[0];
					hv_q      <= stk_rd[SDW-1:SDW-KW];
					hr_q      <= '0;
					hcnt_q    <= '0;
					state_q   <= S_HASH;
				end
				S_HASH: begin
					if (edge_op_q ? EPOW2 : FPOW2) begin
						slot_q  <= hv_q[HSW-1:0] & (edge_op_q ? EMASK : FMASK);
						state_q <= S_PROBE;
					end else begin
						hr_q   <= ht4[HSW-1:0];
						hv_q   <= {hv_q[KW-5:0], 4'd0};
						hcnt_q <= hcnt_q + 6'd1;
						if (hcnt_q == 6'(KW / 4 - 1)) begin
							slot_q  <= ht4[HSW-1:0];
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					if (slot_v) begin
						state_q <= S_ENT;
					end else if (edge_op_q) begin
						level_q  <= level_q + LW'(1);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
						if (32'(eused_q) != 32'(EDGE_ENTRIES)) begin
							eused_q <= eused_q + EUW'(1);
						end else begin
							status_q <= cgp_pkg::ST_EDGE_FULL;
						end
					end else if (32'(fused_q) != 32'(FUNC_ENTRIES)) begin
						fused_q <= fused_q + FUW'(1);
						if (fr_ev_q) begin
							state_q <= S_XER;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						status_q <= cgp_pkg::ST_FUNC_FULL;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_ENT: begin
					if (ent_match) begin
						if (edge_op_q) begin
							level_q <= level_q + LW'(1);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (fr_ev_q) begin
							state_q <= S_XER;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (probe_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (edge_op_q) begin
							level_q  <= level_q + LW'(1);
							status_q <= cgp_pkg::ST_EDGE_FULL;
						end else begin
							status_q <= cgp_pkg::ST_FUNC_FULL;
						end
					end else begin
						n_q     <= n_q + CW'(1);
						slot_q  <= slot_nx;
						state_q <= S_PROBE;
					end
				end
				S_XER: begin
					state_q <= S_XADD;
				end
				S_XADD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RFUNC: begin
					used_q  <= fu32[10:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (32'(ix_q) >= fu32 || 32'(ix_q) >= 32'(FUNC_ENTRIES)) begin
						status_q <= cgp_pkg::ST_RANGE;
					end else begin
						a1_q     <= fent_rd[191:128];
						calls_q  <= fent_rd[127:64];
						cycles_q <= fent_rd[63:0];
					end
				end
				S_REDGE: begin
					used_q  <= eu32[10:0];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (32'(ix_q) >= eu32 || 32'(ix_q) >= 32'(EDGE_ENTRIES)) begin
						status_q <= cgp_pkg::ST_RANGE;
					end else begin
						a1_q     <= eent_rd[255:192];
						a2_q     <= eent_rd[191:128];
						calls_q  <= eent_rd[127:64];
						cycles_q <= eent_rd[63:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	cgp_ram #(.WIDTH(192), .DEPTH(FUNC_ENTRIES)) u_fent (
		.clk(clk), .we(fent_we), .waddr(fent_waddr), .wdata(fent_wdata),
		.raddr(fent_raddr), .rdata(fent_rd)
	);

	cgp_ram #(.WIDTH(FI + 1), .DEPTH(FUNC_SLOTS)) u_fslot (
		.clk(clk), .we(fslot_we), .waddr(fslot_waddr), .wdata(fslot_wdata),
		.raddr(slot_q[FSW-1:0]), .rdata(fslot_rd)
	);

	cgp_ram #(.WIDTH(256), .DEPTH(EDGE_ENTRIES)) u_eent (
		.clk(clk), .we(eent_we), .waddr(eent_waddr), .wdata(eent_wdata),
		.raddr(eent_raddr), .rdata(eent_rd)
	);

	cgp_ram #(.WIDTH(EI + 1), .DEPTH(EDGE_SLOTS)) u_eslot (
		.clk(clk), .we(eslot_we), .waddr(eslot_waddr), .wdata(eslot_wdata),
		.raddr(slot_q[ESW-1:0]), .rdata(eslot_rd)
	);

	cgp_ram #(.WIDTH(SDW), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(lvl_m1[SAW-1:0]), .rdata(stk_rd)
	);

endmodule

>>> hw/rtl/cgp_ram.sv
module cgp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
